### sv/pcl_pkg.sv
// Package for the polyline curve lookup: fixed widths, codes and shared types.
// No dependencies.
`default_nettype none
package pcl_pkg;
  localparam int XW = 18;
  localparam int YW = 17;
  localparam int SW = 24;
  localparam int IDXW = 12;
  localparam int CNTW = 13;
  localparam logic [YW-1:0] UNIT_ONE = 17'd65536;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_IDENT  = 2'd1,
    REG_COUNT  = 2'd2
  } reg_t;

  typedef struct packed {
    logic             req_type;
    logic [IDXW-1:0]  entry_index;
    logic [XW-1:0]    point_x;
    logic [YW-1:0]    point_y;
    logic signed [SW-1:0] point_slope;
    logic [YW-1:0]    query_pos;
  } req_item_t;

  typedef struct packed {
    logic [YW-1:0] curve_value;
    logic          saturated;
  } res_item_t;
endpackage
`default_nettype wire

### sv/pcl_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface pcl_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/polyline_curve_lookup_unit.sv
// Polyline curve lookup: a query passes stage 0, stage 1, the search levels, the final
// read, the multiply stage and the output register; one query per cycle while the result
// is not stalled. A write waits while any query still has table reads ahead; a result
// stall holds all stages. Binary search runs one level per stage, each level reading its
// own x table copy; y and slope are read at the final segment index.
// Reset (rst, synchronous) clears valid bits and resets config regs; tables are not cleared.
`default_nettype none
module polyline_curve_lookup_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pcl_if.sink              req,
  pcl_if.source            res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import pcl_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LV = AW;           // search levels
  localparam int NS = LV + 4;        // valid bits ahead of the output register
  localparam int PW = AW + 1;

  logic          curve_active;
  logic [YW-1:0] identity_value;
  logic [CNTW-1:0] point_count;
  reg_t          reg_sel;

  assign pready = 1'b1;
  assign reg_sel = reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_active <= 1'b0;
      identity_value <= 17'd32768;
      point_count <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_ACTIVE: curve_active <= pwdata[0];
        REG_IDENT:  identity_value <= pwdata[YW-1:0];
        REG_COUNT:  point_count <= pwdata[CNTW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ACTIVE: prdata[0] = curve_active;
      REG_IDENT:  prdata[YW-1:0] = identity_value;
      REG_COUNT:  prdata[CNTW-1:0] = point_count;
      default: ;
    endcase
  end

  // effective count clamped to depth
  logic [31:0] n_eff;
  always_comb begin
    if (32'(point_count) > 32'(TABLE_DEPTH)) n_eff = 32'(TABLE_DEPTH);
    else n_eff = 32'(point_count);
  end

  // pipeline control
  logic [NS-1:0] vld;
  logic adv;
  logic wr_hold;
  logic acc;
  assign adv = !res.valid || res.ready;
  // a write waits until no query still has table reads ahead of it
  assign wr_hold = req.data.req_type == REQ_WRITE && |vld[LV+1:0];
  assign req.ready = adv && !wr_hold;
  assign acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], acc && req.data.req_type == REQ_QUERY};
  end

  logic wr_en;
  logic [AW-1:0] wr_a;
  assign wr_en = acc && req.data.req_type == REQ_WRITE &&
                 32'(req.data.entry_index) < 32'(TABLE_DEPTH);
  assign wr_a = AW'(req.data.entry_index);

  // stage 0: x0 lookup for wrap
  logic [XW-1:0] x_first;
  logic [XW-1:0] x0_rd;
  logic [YW-1:0] t0;
  logic          id0;
  logic [PW-1:0] hi0;
  always_ff @(posedge clk) begin
    if (wr_en && wr_a == '0) x_first <= req.data.point_x;
    if (adv) begin
      x0_rd <= x_first;
      t0 <= req.data.query_pos;
      id0 <= !curve_active || n_eff < 32'd2;
      hi0 <= PW'(n_eff - 32'd1);
    end
  end

  // stage 1: wrapped position, 18 bits (t <= 131071 so t+65536 fits)
  logic [XW-1:0] tw1;
  logic          id1;
  logic [PW-1:0] hi1;
  always_ff @(posedge clk) begin
    if (adv) begin
      tw1 <= (XW'(t0) < x0_rd) ? XW'(t0) + XW'(UNIT_ONE) : XW'(t0);
      id1 <= id0;
      hi1 <= hi0;
    end
  end

  // bounds and position entering search level g
  logic [PW-1:0] lo_c [LV+1];
  logic [PW-1:0] hi_c [LV+1];
  logic [XW-1:0] tw_c [LV+1];
  logic          id_c [LV+1];
  assign lo_c[0] = '0;
  assign hi_c[0] = hi1;
  assign tw_c[0] = tw1;
  assign id_c[0] = id1;

  // search levels: x at mid is read through a registered memory port together
  // with the registered bounds; the compare feeds the next level's address.
  genvar g;
  generate
    for (g = 0; g < LV; g++) begin : g_srch
      logic [XW-1:0] xm [TABLE_DEPTH];
      logic [PW-1:0] mid;
      logic [XW-1:0] x_rd;
      logic          act;
      logic [PW-1:0] lo_r, hi_r, mid_r;
      logic [XW-1:0] tw_r;
      logic          id_r;
      logic          v_r;
      assign act = hi_c[g] > lo_c[g] + PW'(1);
      assign mid = PW'((32'(lo_c[g]) + 32'(hi_c[g])) >> 1);
      always_ff @(posedge clk) begin
        if (wr_en) xm[wr_a] <= req.data.point_x;
        if (adv) x_rd <= xm[mid[AW-1:0]];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          lo_r <= lo_c[g]; hi_r <= hi_c[g]; mid_r <= mid;
          tw_r <= tw_c[g]; id_r <= id_c[g]; v_r <= act;
        end
      end
      assign lo_c[g+1] = (v_r && !(x_rd > tw_r)) ? mid_r : lo_r;
      assign hi_c[g+1] = (v_r && (x_rd > tw_r)) ? mid_r : hi_r;
      assign tw_c[g+1] = tw_r;
      assign id_c[g+1] = id_r;
    end
  endgenerate

  // final: read y and slope at lo
  logic [YW-1:0] ym [TABLE_DEPTH];
  logic [SW-1:0] sm [TABLE_DEPTH];
  logic [XW-1:0] xl [TABLE_DEPTH];
  logic [YW-1:0] y_rd;
  logic signed [SW-1:0] s_rd;
  logic [XW-1:0] xl_rd, twf;
  logic idf;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ym[wr_a] <= req.data.point_y;
      sm[wr_a] <= req.data.point_slope;
      xl[wr_a] <= req.data.point_x;
    end
    if (adv) begin
      y_rd <= ym[lo_c[LV][AW-1:0]];
      s_rd <= sm[lo_c[LV][AW-1:0]];
      xl_rd <= xl[lo_c[LV][AW-1:0]];
      twf <= tw_c[LV];
      idf <= id_c[LV];
    end
  end

  // multiply stage
  logic signed [XW:0] dx;
  logic signed [XW+SW:0] prod;
  logic [YW-1:0] y_m;
  logic idm;
  assign dx = $signed({1'b0, twf}) - $signed({1'b0, xl_rd});
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= (XW+SW+1)'(dx) * (XW+SW+1)'(s_rd);
      y_m <= y_rd;
      idm <= idf;
    end
  end

  // round, add, clamp -> output register
  logic signed [XW+SW+1:0] rp, val;
  res_item_t outv;
  always_comb begin
    rp = ((XW+SW+2)'(prod) + (XW+SW+2)'(32768)) >>> 16;
    val = rp + $signed((XW+SW+2)'(y_m));
    if (idm) begin
      outv.saturated = identity_value > UNIT_ONE;
      outv.curve_value = outv.saturated ? UNIT_ONE : identity_value;
    end else if (val < 0) begin
      outv.curve_value = '0; outv.saturated = 1'b1;
    end else if (val > $signed((XW+SW+2)'(UNIT_ONE))) begin
      outv.curve_value = UNIT_ONE; outv.saturated = 1'b1;
    end else begin
      outv.curve_value = YW'(val); outv.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (adv) res.valid <= vld[LV+3];
  end
  always_ff @(posedge clk) begin
    if (adv) res.data <= outv;
  end
endmodule
`default_nettype wire
